[hdl/cpu8_pkg.sv]
// ----------------------------------------------------------------------------
// cpu8_pkg: code page 437 / UTF-8 transcoder shared definitions
// Glyph table, reverse lookup and the front-to-back queue entry type.
// ----------------------------------------------------------------------------
package cpu8_pkg;

  localparam logic [7:0] UNMAPPED_BYTE = 8'h3F;
  localparam int         QDEPTH        = 2;
  localparam int         QAW           = $clog2(QDEPTH);

  // kinds of work handed to the back end
  typedef enum logic [1:0] {
    KIND_DEC = 2'b01,   // one code page byte out
    KIND_ENC = 2'b10    // one to three UTF-8 bytes out
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  cp_byte;   // decode result byte
    logic [1:0]  nbytes;    // encode: output count
    logic [23:0] utf;       // encode: bytes, first in [23:16]
  } qent_t;

  // glyph of a code page byte
  function automatic logic [15:0] glyph_of(input logic [7:0] b);
    logic [15:0] g;
    if (b < 8'h20) begin
      unique case (b[4:0])
        5'd0:  g = 16'h0000; 5'd1:  g = 16'h263A; 5'd2:  g = 16'h263B; 5'd3:  g = 16'h2665;
        5'd4:  g = 16'h2666; 5'd5:  g = 16'h2663; 5'd6:  g = 16'h2660; 5'd7:  g = 16'h2022;
        5'd8:  g = 16'h25D8; 5'd9:  g = 16'h25CB; 5'd10: g = 16'h000A; 5'd11: g = 16'h2642;
        5'd12: g = 16'h2640; 5'd13: g = 16'h266A; 5'd14: g = 16'h266B; 5'd15: g = 16'h263C;
        5'd16: g = 16'h25BA; 5'd17: g = 16'h25C4; 5'd18: g = 16'h2195; 5'd19: g = 16'h203C;
        5'd20: g = 16'h00B6; 5'd21: g = 16'h00A7; 5'd22: g = 16'h25AC; 5'd23: g = 16'h21A8;
        5'd24: g = 16'h2191; 5'd25: g = 16'h2193; 5'd26: g = 16'h2192; 5'd27: g = 16'h2190;
        5'd28: g = 16'h221F; 5'd29: g = 16'h2194; 5'd30: g = 16'h25B2; default: g = 16'h25BC;
      endcase
    end else if (b < 8'h7F) begin
      g = {8'h00, b};
    end else if (b == 8'h7F) begin
      g = 16'h2302;
    end else begin
      unique case (b[6:0])
        7'd0:   g = 16'h00C7; 7'd1:   g = 16'h00FC; 7'd2:   g = 16'h00E9; 7'd3:   g = 16'h00E2;
        7'd4:   g = 16'h00E4; 7'd5:   g = 16'h00E0; 7'd6:   g = 16'h00E5; 7'd7:   g = 16'h00E7;
        7'd8:   g = 16'h00EA; 7'd9:   g = 16'h00EB; 7'd10:  g = 16'h00E8; 7'd11:  g = 16'h00EF;
        7'd12:  g = 16'h00EE; 7'd13:  g = 16'h00EC; 7'd14:  g = 16'h00C4; 7'd15:  g = 16'h00C5;
        7'd16:  g = 16'h00C9; 7'd17:  g = 16'h00E6; 7'd18:  g = 16'h00C6; 7'd19:  g = 16'h00F4;
        7'd20:  g = 16'h00F6; 7'd21:  g = 16'h00F2; 7'd22:  g = 16'h00FB; 7'd23:  g = 16'h00F9;
        7'd24:  g = 16'h00FF; 7'd25:  g = 16'h00D6; 7'd26:  g = 16'h00DC; 7'd27:  g = 16'h00A2;
        7'd28:  g = 16'h00A3; 7'd29:  g = 16'h00A5; 7'd30:  g = 16'h20A7; 7'd31:  g = 16'h0192;
        7'd32:  g = 16'h00E1; 7'd33:  g = 16'h00ED; 7'd34:  g = 16'h00F3; 7'd35:  g = 16'h00FA;
        7'd36:  g = 16'h00F1; 7'd37:  g = 16'h00D1; 7'd38:  g = 16'h00AA; 7'd39:  g = 16'h00BA;
        7'd40:  g = 16'h00BF; 7'd41:  g = 16'h2310; 7'd42:  g = 16'h00AC; 7'd43:  g = 16'h00BD;
        7'd44:  g = 16'h00BC; 7'd45:  g = 16'h00A1; 7'd46:  g = 16'h00AB; 7'd47:  g = 16'h00BB;
        7'd48:  g = 16'h2591; 7'd49:  g = 16'h2592; 7'd50:  g = 16'h2593; 7'd51:  g = 16'h2502;
        7'd52:  g = 16'h2524; 7'd53:  g = 16'h2561; 7'd54:  g = 16'h2562; 7'd55:  g = 16'h2556;
        7'd56:  g = 16'h2555; 7'd57:  g = 16'h2563; 7'd58:  g = 16'h2551; 7'd59:  g = 16'h2557;
        7'd60:  g = 16'h255D; 7'd61:  g = 16'h255C; 7'd62:  g = 16'h255B; 7'd63:  g = 16'h2510;
        7'd64:  g = 16'h2514; 7'd65:  g = 16'h2534; 7'd66:  g = 16'h252C; 7'd67:  g = 16'h251C;
        7'd68:  g = 16'h2500; 7'd69:  g = 16'h253C; 7'd70:  g = 16'h255E; 7'd71:  g = 16'h255F;
        7'd72:  g = 16'h255A; 7'd73:  g = 16'h2554; 7'd74:  g = 16'h2569; 7'd75:  g = 16'h2566;
        7'd76:  g = 16'h2560; 7'd77:  g = 16'h2550; 7'd78:  g = 16'h256C; 7'd79:  g = 16'h2567;
        7'd80:  g = 16'h2568; 7'd81:  g = 16'h2564; 7'd82:  g = 16'h2565; 7'd83:  g = 16'h2559;
        7'd84:  g = 16'h2558; 7'd85:  g = 16'h2552; 7'd86:  g = 16'h2553; 7'd87:  g = 16'h256B;
        7'd88:  g = 16'h256A; 7'd89:  g = 16'h2518; 7'd90:  g = 16'h250C; 7'd91:  g = 16'h2588;
        7'd92:  g = 16'h2584; 7'd93:  g = 16'h258C; 7'd94:  g = 16'h2590; 7'd95:  g = 16'h2580;
        7'd96:  g = 16'h03B1; 7'd97:  g = 16'h00DF; 7'd98:  g = 16'h0393; 7'd99:  g = 16'h03C0;
        7'd100: g = 16'h03A3; 7'd101: g = 16'h03C3; 7'd102: g = 16'h00B5; 7'd103: g = 16'h03C4;
        7'd104: g = 16'h03A6; 7'd105: g = 16'h0398; 7'd106: g = 16'h03A9; 7'd107: g = 16'h03B4;
        7'd108: g = 16'h221E; 7'd109: g = 16'h03C6; 7'd110: g = 16'h03B5; 7'd111: g = 16'h2229;
        7'd112: g = 16'h2261; 7'd113: g = 16'h00B1; 7'd114: g = 16'h2265; 7'd115: g = 16'h2264;
        7'd116: g = 16'h2320; 7'd117: g = 16'h2321; 7'd118: g = 16'h00F7; 7'd119: g = 16'h2248;
        7'd120: g = 16'h00B0; 7'd121: g = 16'h2219; 7'd122: g = 16'h00B7; 7'd123: g = 16'h221A;
        7'd124: g = 16'h207F; 7'd125: g = 16'h00B2; 7'd126: g = 16'h25A0; default: g = 16'h00A9;
      endcase
    end
    return g;
  endfunction

  // reverse lookup: 256 parallel compares, highest matching byte wins
  function automatic logic [7:0] byte_of(input logic [20:0] cp);
    logic [7:0] r;
    r = UNMAPPED_BYTE;
    for (int i = 0; i < 256; i++) begin
      if ({5'd0, glyph_of(8'(i))} == cp) r = 8'(i);
    end
    return r;
  endfunction

endpackage

[hdl/cpu8_front.sv]
// ----------------------------------------------------------------------------
// cpu8_front: input side
// Gathers UTF-8 sequences (decode) or encodes glyphs to UTF-8 (encode), and registers the result for the queue.
// ----------------------------------------------------------------------------
module cpu8_front import cpu8_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        direction,
  input  logic        clr,       // config write: drop open sequence
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        push,
  output qent_t       push_ent,
  input  logic        q_full
);

  logic [20:0] part_r, part_nxt;
  logic [1:0]  pend_r, pend_nxt;
  logic        st_v_r, st_v_nxt;   // staged lookup waiting for queue
  qent_t       st_r, st_nxt;
  logic        acc;
  logic        emit;
  logic [20:0] cp;
  logic [15:0] g;

  assign push     = st_v_r && !q_full;
  assign push_ent = st_r;
  assign in_ready = !st_v_r || !q_full;
  assign acc      = in_valid && in_ready;
  assign g        = glyph_of(in_byte);

  // sequence assembly
  always_comb begin
    part_nxt = part_r;
    pend_nxt = pend_r;
    emit     = 1'b0;
    cp       = {13'd0, in_byte};
    if (acc && !direction) begin
      if (pend_r != 2'd0) begin
        cp       = {part_r[14:0], in_byte[5:0]};
        pend_nxt = pend_r - 2'd1;
        part_nxt = cp;
        if (pend_r == 2'd1) begin
          emit     = 1'b1;
          part_nxt = '0;
        end
      end else if (in_byte[7:5] == 3'b110) begin
        part_nxt = {16'd0, in_byte[4:0]};
        pend_nxt = 2'd1;
      end else if (in_byte[7:4] == 4'b1110) begin
        part_nxt = {17'd0, in_byte[3:0]};
        pend_nxt = 2'd2;
      end else if (in_byte[7:3] == 5'b11110) begin
        part_nxt = {18'd0, in_byte[2:0]};
        pend_nxt = 2'd3;
      end else begin
        emit = 1'b1;
      end
    end
    if (clr) begin
      part_nxt = '0;
      pend_nxt = '0;
    end
  end

  // staging register
  always_comb begin
    st_v_nxt = st_v_r && q_full;
    st_nxt   = st_r;
    if (acc) begin
      if (direction) begin
        st_v_nxt        = 1'b1;
        st_nxt.kind     = KIND_ENC;
        st_nxt.cp_byte  = '0;
        if (g < 16'h0080) begin
          st_nxt.nbytes = 2'd1;
          st_nxt.utf    = {g[7:0], 16'd0};
        end else if (g < 16'h0800) begin
          st_nxt.nbytes = 2'd2;
          st_nxt.utf    = {3'b110, g[10:6], 2'b10, g[5:0], 8'd0};
        end else begin
          st_nxt.nbytes = 2'd3;
          st_nxt.utf    = {4'b1110, g[15:12], 2'b10, g[11:6], 2'b10, g[5:0]};
        end
      end else if (emit) begin
        st_v_nxt       = 1'b1;
        st_nxt.kind    = KIND_DEC;
        st_nxt.cp_byte = byte_of(cp);
        st_nxt.nbytes  = 2'd1;
        st_nxt.utf     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_r <= '0;
      pend_r <= '0;
      st_v_r <= 1'b0;
    end else begin
      part_r <= part_nxt;
      pend_r <= pend_nxt;
      st_v_r <= st_v_nxt;
    end
    st_r <= st_nxt;
  end

endmodule

[hdl/cpu8_queue.sv]
// ----------------------------------------------------------------------------
// cpu8_queue: small FIFO between front and back
// Two entries of register storage, full/empty by count.
// ----------------------------------------------------------------------------
module cpu8_queue import cpu8_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t push_ent,
  output logic  full,
  output logic  nempty,
  input  logic  pop,
  output qent_t head
);

  qent_t          mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;

  assign full   = cnt_r == (QAW+1)'(QDEPTH);
  assign nempty = cnt_r != '0;
  assign head   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
    end
    if (push) mem_r[wp_r] <= push_ent;
  end

endmodule

[hdl/cpu8_back.sv]
// ----------------------------------------------------------------------------
// cpu8_back: output side
// Serializes one queue entry into one to three output words.
// ----------------------------------------------------------------------------
module cpu8_back import cpu8_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       nempty,
  input  qent_t      head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic [1:0] idx_r, idx_nxt;   // word index within entry
  logic       last_w;

  assign out_valid = nempty;
  assign last_w    = (idx_r + 2'd1) == head.nbytes;
  assign out_last  = last_w;
  assign pop       = nempty && out_ready && last_w;

  // select current word
  always_comb begin
    if (head.kind == KIND_DEC) begin
      out_byte = head.cp_byte;
    end else begin
      unique case (idx_r)
        2'd0:    out_byte = head.utf[23:16];
        2'd1:    out_byte = head.utf[15:8];
        default: out_byte = head.utf[7:0];
      endcase
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (nempty && out_ready) idx_nxt = last_w ? 2'd0 : idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= '0;
    else        idx_r <= idx_nxt;
  end

endmodule

[hdl/cp437_utf8_transcoder.sv]
// ----------------------------------------------------------------------------
// cp437_utf8_transcoder: code page 437 <-> UTF-8 byte stream converter
// Data path: lookup register, then queue, then output. Throughput: one input
// word per cycle while the output keeps up; the output drains one word per
// cycle, and each encoded input gives one to three output words.
// Reset: synchronous active low; direction 0 (decode), no sequence open.
// ----------------------------------------------------------------------------
module cp437_utf8_transcoder import cpu8_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_direction,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic  dir_r;
  logic  cfg_wr;
  logic  push, q_full, nempty, pop;
  qent_t push_ent, head;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // direction register
  always_ff @(posedge clk) begin
    if (!rst_n)      dir_r <= 1'b0;
    else if (cfg_wr) dir_r <= cfg_direction;
  end

  cpu8_front u_front (
    .clk, .rst_n, .direction(dir_r), .clr(cfg_wr),
    .in_valid, .in_ready, .in_byte,
    .push, .push_ent, .q_full
  );

  cpu8_queue u_queue (
    .clk, .rst_n, .push, .push_ent, .full(q_full), .nempty, .pop, .head
  );

  cpu8_back u_back (
    .clk, .rst_n, .nempty, .head, .pop,
    .out_valid, .out_ready, .out_byte, .out_last
  );

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb: code page 437 / UTF-8 transcoder testbench
// Drives byte streams in both directions through valid/ready with random
// bursts and output stalls, predicts every output word from a behavioral
// copy of the glyph table and the UTF-8 gatherer, and checks word by word.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] QMARK        = 8'h3F;
  localparam logic       DIR_DECODE   = 1'b0;
  localparam logic       DIR_ENCODE   = 1'b1;
  localparam int         DRAIN_CYCLES = 8;

  logic       clk;
  logic       rst_n;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_direction;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       out_last;

  cp437_utf8_transcoder u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_direction(cfg_direction),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_last     (out_last)
  );

  typedef struct {
    logic [7:0] data;
    logic       last;
  } out_word_t;

  // predictor state
  logic        dir_q;
  logic [20:0] cp_acc;
  logic [1:0]  cont_left;
  logic [2:0]  seq_len;
  logic [15:0] glyph_tab [256];
  out_word_t   pending_words [$];

  int  errors;
  bit  long_stall;

  // glyph table built from its four ranges
  initial begin
    logic [15:0] lo [32];
    logic [15:0] hi [128];
    lo = '{16'h0000, 16'h263A, 16'h263B, 16'h2665, 16'h2666, 16'h2663, 16'h2660, 16'h2022,
           16'h25D8, 16'h25CB, 16'h000A, 16'h2642, 16'h2640, 16'h266A, 16'h266B, 16'h263C,
           16'h25BA, 16'h25C4, 16'h2195, 16'h203C, 16'h00B6, 16'h00A7, 16'h25AC, 16'h21A8,
           16'h2191, 16'h2193, 16'h2192, 16'h2190, 16'h221F, 16'h2194, 16'h25B2, 16'h25BC};
    hi = '{16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
           16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
           16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
           16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
           16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
           16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
           16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
           16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
           16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
           16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
           16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
           16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
           16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
           16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
           16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
           16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A9};
    for (int i = 0; i < 256; i++) begin
      if (i < 32) glyph_tab[i] = lo[i];
      else if (i < 127) glyph_tab[i] = 16'(i);
      else if (i == 127) glyph_tab[i] = 16'h2302;
      else glyph_tab[i] = hi[i - 128];
    end
  end

  // reverse lookup, highest byte wins
  function automatic logic [7:0] cp_to_byte(input logic [20:0] cp);
    for (int i = 255; i >= 0; i--) begin
      if ({5'd0, glyph_tab[i]} == cp) return 8'(i);
    end
    return QMARK;
  endfunction

  function automatic void push_word(input logic [7:0] d, input logic l);
    out_word_t w;
    w.data = d;
    w.last = l;
    pending_words.insert(pending_words.size(), w);
  endfunction

  // advance the converter model by one accepted input word
  function automatic void convert_word(input logic [7:0] b);
    logic [15:0] g;
    if (dir_q == DIR_ENCODE) begin
      g = glyph_tab[b];
      if (g < 16'h80) begin
        push_word(g[7:0], 1'b1);
      end else if (g < 16'h800) begin
        push_word(8'hC0 | 8'(g >> 6), 1'b0);
        push_word(8'h80 | 8'(g[5:0]), 1'b1);
      end else begin
        push_word(8'hE0 | 8'(g[15:12]), 1'b0);
        push_word(8'h80 | 8'(g[11:6]), 1'b0);
        push_word(8'h80 | 8'(g[5:0]), 1'b1);
      end
    end else if (cont_left != 2'd0) begin
      cp_acc    = {cp_acc[14:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        push_word(cp_to_byte(cp_acc), 1'b1);
        cp_acc  = '0;
        seq_len = '0;
      end
    end else if (b[7:5] == 3'b110) begin
      cp_acc = 21'(b[4:0]); cont_left = 2'd1; seq_len = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      cp_acc = 21'(b[3:0]); cont_left = 2'd2; seq_len = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      cp_acc = 21'(b[2:0]); cont_left = 2'd3; seq_len = 3'd4;
    end else begin
      push_word(cp_to_byte(21'(b)), 1'b1);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // output checker
  always @(posedge clk) begin
    out_word_t w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word", out_byte, 8'h00);
      end else begin
        w = pending_words.pop_front();
        if (out_byte !== w.data) report_mismatch("out_byte", out_byte, w.data);
        if (out_last !== w.last) report_mismatch("out_last", 8'(out_last), 8'(w.last));
      end
    end
  end

  // receiver stall pattern, with a long hold-off on request
  initial begin
    int phase;
    out_ready = 1'b0;
    phase = 0;
    forever begin
      @(posedge clk);
      phase++;
      if (long_stall) out_ready <= 1'b0;
      else if ((phase / 200) % 3 == 2) out_ready <= 1'b1;
      else out_ready <= (($urandom_range(0, 9) < 7) && (phase % 7 != 3));
    end
  end

  task automatic write_direction(input logic d);
    cfg_valid     <= 1'b1;
    cfg_direction <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    dir_q     = d;
    cp_acc    = '0;
    cont_left = '0;
    seq_len   = '0;
  endtask

  // wait until every expected word is back, then let the pipe settle
  task automatic wait_idle();
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // send one word, holding valid through to acceptance; gaps between bursts;
  // the accepted word feeds the predictor
  int burst_left;
  task automatic send_word(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    convert_word(b);
    burst_left--;
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // random UTF-8 stream: mostly well-formed sequences, some noise
  task automatic send_utf8_random(input int n);
    logic [15:0] g;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      if (k < 7) begin
        g = glyph_tab[$urandom_range(0, 255)];
        if ($urandom_range(0, 7) == 0) g = 16'($urandom);
        if (g < 16'h80) begin
          send_word(g[7:0]);
        end else if (g < 16'h800) begin
          send_word(8'hC0 | 8'(g >> 6));
          send_word(8'h80 | 8'(g[5:0]));
        end else begin
          send_word(8'hE0 | 8'(g[15:12]));
          send_word(8'h80 | 8'(g[11:6]));
          send_word(8'h80 | 8'(g[5:0]));
        end
      end else if (k < 9) begin
        send_word(8'($urandom));
      end else begin
        // four-byte sequence, random content
        send_word(8'hF0 | 8'($urandom_range(0, 7)));
        repeat (3) send_word(8'($urandom));
      end
    end
  endtask

  // directed table: direction, byte, whether the result is typed in, value
  typedef struct {
    logic       dir;
    logic [7:0] data;
    bit         fixed;
    logic [7:0] want;
  } dir_row_t;

  dir_row_t rows [] = '{
    '{DIR_DECODE, 8'h00, 1, 8'h00},   // NUL maps to itself
    '{DIR_DECODE, 8'h0A, 1, 8'h0A},   // newline
    '{DIR_DECODE, 8'h7F, 1, QMARK},   // raw 0x7F is unmapped
    '{DIR_DECODE, 8'h80, 1, QMARK},   // invalid lead
    '{DIR_DECODE, 8'hFF, 1, 8'h98},   // invalid lead, U+00FF sits at 0x98
    '{DIR_DECODE, 8'hC2, 0, 8'h00},   // two-byte: U+00A9 -> 0xFF
    '{DIR_DECODE, 8'hA9, 1, 8'hFF},
    '{DIR_DECODE, 8'hE2, 0, 8'h00},   // three-byte: U+263A
    '{DIR_DECODE, 8'h98, 0, 8'h00},
    '{DIR_DECODE, 8'hBA, 1, 8'h01},
    '{DIR_DECODE, 8'hF7, 0, 8'h00},   // four-byte, bad continuations
    '{DIR_DECODE, 8'h00, 0, 8'h00},
    '{DIR_DECODE, 8'hFF, 0, 8'h00},
    '{DIR_DECODE, 8'h3F, 0, 8'h00},
    '{DIR_DECODE, 8'hE0, 0, 8'h00},   // left open: the direction write clears it
    '{DIR_ENCODE, 8'h00, 1, 8'h00},
    '{DIR_ENCODE, 8'h7E, 1, 8'h7E},
    '{DIR_ENCODE, 8'h7F, 0, 8'h00},
    '{DIR_ENCODE, 8'h80, 0, 8'h00},
    '{DIR_ENCODE, 8'hFF, 0, 8'h00},
    '{DIR_ENCODE, 8'h01, 0, 8'h00},
    '{DIR_DECODE, 8'hC7, 0, 8'h00},   // two-byte with bad continuation: U+01C1
    '{DIR_DECODE, 8'h41, 1, QMARK}
  };

  // test sequence
  initial begin
    logic cur_dir;
    errors        = 0;
    long_stall    = 1'b0;
    burst_left    = 0;
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_direction = 1'b0;
    in_valid      = 1'b0;
    in_byte       = 8'h00;
    dir_q         = DIR_DECODE;
    cp_acc        = '0;
    cont_left     = '0;
    seq_len       = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, from reset default (decode)
    cur_dir = DIR_DECODE;
    foreach (rows[i]) begin
      if (rows[i].dir != cur_dir) begin
        end_burst();
        wait_idle();
        write_direction(rows[i].dir);
        cur_dir = rows[i].dir;
      end
      send_word(rows[i].data);
      if (rows[i].fixed && pending_words.size() != 0 &&
          pending_words[pending_words.size() - 1].data !== rows[i].want)
        report_mismatch("directed", pending_words[pending_words.size() - 1].data,
                        rows[i].want);
    end
    end_burst();
    wait_idle();

    // random phases alternating direction
    for (int ph = 0; ph < 6; ph++) begin
      write_direction(ph[0] ? DIR_DECODE : DIR_ENCODE);
      if (ph == 1) begin
        // long receiver hold-off while the sender keeps offering
        fork
          begin
            long_stall = 1'b1;
            repeat (60) @(posedge clk);
            long_stall = 1'b0;
          end
          begin
            for (int i = 0; i < 20; i++) send_word(8'($urandom));
          end
        join
        end_burst();
        wait_idle();
      end
      if (dir_q == DIR_ENCODE) begin
        for (int i = 0; i < 80; i++) send_word(8'($urandom));
      end else begin
        send_utf8_random(50);
      end
      end_burst();
      wait_idle();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      if (pending_words.size() != 0)
        $display("%0d expected words never arrived", pending_words.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
